// ----- rtl/core/sha1_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 hash block.
// Depends on nothing; every module of the block imports it.
package sha1_pkg;

    // Word counts, round and padding bounds, and the initial chaining words.
    localparam int unsigned NUM_WORDS  = 5;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [6:0]  SCHED_LEN  = 7'd16;
    localparam logic [2:0]  LAST_WORD  = 3'd4;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [5:0]  BLOCK_LAST = 6'd63;
    localparam logic [7:0]  PAD_MARK   = 8'h80;

    localparam logic [31:0] INIT_H [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    // Padding phases: marker byte, zero fill, length bytes.
    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_pad_phase;

    // Round groups of twenty.
    typedef enum logic [1:0] {
        RC_CH,
        RC_PAR1,
        RC_MAJ,
        RC_PAR2
    } t_round_class;

    // Controls for the compression unit.
    typedef struct packed {
        logic init_chain;
        logic load_work;
        logic round;
        logic fold;
    } t_comp_ctl;

    // Controls for the message schedule window.
    typedef struct packed {
        logic shift_byte;
        logic step;
        logic early;
    } t_sched_ctl;

    function automatic t_round_class round_class(input logic [6:0] idx);
        t_round_class rc;
        if (idx < 7'd20) begin
            rc = RC_CH;
        end else if (idx < 7'd40) begin
            rc = RC_PAR1;
        end else if (idx < 7'd60) begin
            rc = RC_MAJ;
        end else begin
            rc = RC_PAR2;
        end
        return rc;
    endfunction

    function automatic logic [31:0] round_k(input t_round_class rc);
        logic [31:0] k;
        case (rc)
            RC_CH:   k = 32'h5A827999;
            RC_PAR1: k = 32'h6ED9EBA1;
            RC_MAJ:  k = 32'h8F1BBCDC;
            RC_PAR2: k = 32'hCA62C1D6;
            default: k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input t_round_class rc, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rc)
            RC_CH:   f = (b & c) | (~b & d);
            RC_MAJ:  f = (b & c) | (b & d) | (c & d);
            RC_PAR1: f = b ^ c ^ d;
            RC_PAR2: f = b ^ c ^ d;
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/sha1_hash_top.sv -----
// SHA-1 hash over a byte stream: sequencer, padding, length count and digest output.
// Depends on sha1_pkg, sha1_sched and sha1_comp.
//
// Usage: each input beat carries a message byte, a flag saying the byte is present,
// and an end flag. A beat without a byte but with the end flag closes an empty or
// already complete message. A beat with neither changes nothing.
// Input: a beat that does not complete a 64-byte block is taken without a stall.
// The beat that completes a block holds o_in_stall through 80 rounds in the single
// shared round adder and then the fold into the chain.
// At the end of a message the padding sequencer pushes one byte per cycle to the end
// of the block, pausing for the rounds and the fold of each padded block (one or two
// blocks); then five output beats carry digest words 0 to 4, the fifth marked last.
// o_in_stall stays high from the end beat until the fifth word is taken.
// A stall on the output holds the current word steady; nothing is lost.
// Reset (synchronous, active low) loads the initial chaining words and clears the
// byte and bit counts; after the digest the block returns to that same state.
module sha1_hash_top
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state     r_state, n_state;
    t_pad_phase r_phase, n_phase;
    logic [5:0]  r_fill;
    logic [63:0] r_bit_len;
    logic [6:0]  r_round;
    logic [2:0]  r_word;
    logic        r_finish;

    logic        in_acc, out_acc, push_in, pad_push, push, block_full, round_last, word_last;
    logic [7:0]  push_byte, pad_byte, len_byte;
    t_comp_ctl   comp_ctl;
    t_sched_ctl  sched_ctl;
    logic [31:0] sched_w;

    // Handshake qualifiers.
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign out_acc    = (r_state == ST_OUT) && !i_out_stall;
    assign push_in    = in_acc && i_byte_present;
    assign pad_push   = (r_state == ST_PAD);
    assign push       = push_in || pad_push;
    assign block_full = push && (r_fill == BLOCK_LAST);
    assign round_last = (r_round == LAST_ROUND);
    assign word_last  = (r_word == LAST_WORD);

    // Padding byte: marker, zeros up to offset 56, then the big-endian bit count.
    assign len_byte = 8'(r_bit_len >> {~r_fill[2:0], 3'b000});
    always_comb begin
        case (r_phase)
            PH_MARK: pad_byte = PAD_MARK;
            PH_ZERO: pad_byte = (r_fill == LEN_START) ? len_byte : 8'h00;
            PH_LEN:  pad_byte = len_byte;
            default: pad_byte = 8'h00;
        endcase
    end
    assign push_byte = push_in ? i_message_byte : pad_byte;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (block_full) begin
                        n_state = ST_COMP;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (round_last) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_finish) begin
                    n_state = (r_phase == PH_LEN) ? ST_OUT : ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    n_state = ST_COMP;
                end
            end
            ST_OUT: begin
                if (out_acc && word_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and unit controls.
    always_comb begin
        o_in_stall           = (r_state != ST_IDLE);
        o_out_valid          = (r_state == ST_OUT);
        o_word_index         = r_word;
        o_last_word          = (r_state == ST_OUT) && word_last;
        comp_ctl.init_chain  = out_acc && word_last;
        comp_ctl.load_work   = block_full;
        comp_ctl.round       = (r_state == ST_COMP);
        comp_ctl.fold        = (r_state == ST_FOLD);
        sched_ctl.shift_byte = push;
        sched_ctl.step       = (r_state == ST_COMP);
        sched_ctl.early      = (r_round < SCHED_LEN);
    end

    // Padding phase advance.
    always_comb begin
        n_phase = r_phase;
        if (pad_push) begin
            case (r_phase)
                PH_MARK: n_phase = PH_ZERO;
                PH_ZERO: n_phase = (r_fill == LEN_START) ? PH_LEN : PH_ZERO;
                PH_LEN:  n_phase = PH_LEN;
                default: n_phase = PH_MARK;
            endcase
        end
    end

    // Sequencer registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_MARK;
            r_fill    <= '0;
            r_bit_len <= '0;
            r_round   <= '0;
            r_word    <= '0;
            r_finish  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= comp_ctl.init_chain ? PH_MARK : n_phase;
            if (comp_ctl.init_chain) begin
                r_fill <= '0;
            end else if (push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (comp_ctl.init_chain) begin
                r_bit_len <= '0;
            end else if (push_in) begin
                r_bit_len <= r_bit_len + 64'd8;
            end
            if (r_state == ST_COMP) begin
                r_round <= round_last ? 7'd0 : r_round + 7'd1;
            end
            if (out_acc) begin
                r_word <= word_last ? 3'd0 : r_word + 3'd1;
            end
            if (comp_ctl.init_chain) begin
                r_finish <= 1'b0;
            end else if (in_acc && i_end_of_message) begin
                r_finish <= 1'b1;
            end
        end
    end

    sha1_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_byte (push_byte),
        .o_w    (sched_w)
    );

    sha1_comp u_comp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (comp_ctl),
        .i_round_idx (r_round),
        .i_w         (sched_w),
        .i_word_sel  (r_word),
        .o_word      (o_digest_word)
    );

    // The input side is held off while digest words are offered.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while digest words pending");

    // Only word four carries the last flag.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == LAST_WORD)))
        else $error("last flag does not match word index");

    // An ending beat always starts padding or compression.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_message) |=> o_in_stall)
        else $error("end of message did not start finalization");

    // Rounds run only while compressing: outside it the round counter rests at zero.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_COMP) |-> (r_round == 7'd0))
        else $error("round counter left nonzero outside compression");

    // A full block always enters compression with a fresh round count.
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        block_full |=> (r_state == ST_COMP) && (r_round == 7'd0) && (r_fill == 6'd0))
        else $error("block did not start compression cleanly");

endmodule

// ----- rtl/core/sha1_sched.sv -----
// Message schedule window: collects message bytes and expands the schedule words.
// Depends on sha1_pkg for the control struct.
module sha1_sched
    import sha1_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    input  logic [7:0] i_byte,
    output logic [31:0] o_w
);

    // Sixteen words, word 0 (oldest) in the top bits.
    logic [511:0] r_win;
    logic [511:0] n_win;
    logic [31:0]  word0, word2, word8, word13, mix;

    assign word0  = r_win[511:480];
    assign word2  = r_win[447:416];
    assign word8  = r_win[255:224];
    assign word13 = r_win[95:64];
    assign mix    = word13 ^ word8 ^ word2 ^ word0;

    // The first sixteen rounds replay the stored words; later rounds expand.
    assign o_w = i_ctl.early ? word0 : {mix[30:0], mix[31]};

    // Bytes shift in at the bottom; each round shifts a whole word.
    always_comb begin
        n_win = r_win;
        if (i_ctl.shift_byte) begin
            n_win = {r_win[503:0], i_byte};
        end else if (i_ctl.step) begin
            n_win = {r_win[479:0], o_w};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// ----- rtl/core/sha1_comp.sv -----
// Compression unit: chaining words, working variables and the shared round logic.
// Depends on sha1_pkg for round functions, constants and the control struct.
module sha1_comp
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_comp_ctl   i_ctl,
    input  logic [6:0]  i_round_idx,
    input  logic [31:0] i_w,
    input  logic [2:0]  i_word_sel,
    output logic [31:0] o_word
);

    logic [31:0] r_h [NUM_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_t;
    t_round_class rc;

    // One SHA-1 round: the five-operand add is the shared datapath.
    assign rc  = round_class(i_round_idx);
    assign n_t = {r_a[26:0], r_a[31:27]} + round_f(rc, r_b, r_c, r_d) + r_e
               + round_k(rc) + i_w;

    assign o_word = r_h[i_word_sel];

    // Working variables load from the chain, then step once per round.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.round) begin
            r_a <= n_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Chaining words: set to the initial values on reset and after a digest, fold in after each block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init_chain) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= INIT_H[i];
            end
        end else if (i_ctl.fold) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for sha1_hash_top: byte beats in, five digest words out.
// Depends on sha1_pkg and sha1_hash_top; carries its own SHA-1 predictor.
`timescale 1ns / 1ps

module tb;
    import sha1_pkg::*;

    // Run shape.
    localparam int RAND_ITEMS   = 210;
    localparam int MIN_MSGS     = 3;
    localparam int HOLD_AT_BEAT = 50;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_TAIL   = 200;
    localparam int NUM_DIRECTED = 16;

    localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    // Well-known digests of the empty string and of "abc".
    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam logic [159:0] NO_DIGEST    = 160'h0;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    typedef struct packed {
        logic [7:0]   msg_byte;
        logic         present;
        logic         finish;
        logic         typed;
        logic [159:0] digest;
    } t_directed_row;

    // Directed beats: empty message, "abc", ignored beats, extremes, byte with end.
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h5A, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'hA5, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h7F, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_DIGEST}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_message_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Predictor state.
    logic [31:0] hash_words [NUM_WORDS];
    logic [7:0]  pend_bytes [64];
    int          pend_fill;
    logic [63:0] msg_bit_count;

    t_digest_beat expected_digest_q [$];

    int mismatch_count  = 0;
    int beats_sent      = 0;
    int counted_items   = 0;
    int messages_closed = 0;
    int words_checked   = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int recv_beats_seen = 0;
    bit long_hold_done  = 1'b0;

    sha1_hash_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_message_byte   (i_message_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Timeout: %0d digest words still outstanding", expected_digest_q.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void clear_hash_state();
        int i;
        for (i = 0; i < NUM_WORDS; i++) hash_words[i] = INIT_H[i];
        pend_fill     = 0;
        msg_bit_count = 64'd0;
    endfunction

    // One 80-round compression of the buffered block into the chaining words.
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = {pend_bytes[4*r], pend_bytes[4*r+1], pend_bytes[4*r+2], pend_bytes[4*r+3]};
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w[r%16] = rol32(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            t = rol32(a, 5) + f + e + k + w[r%16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        pend_bytes[pend_fill] = v;
        pend_fill++;
        if (pend_fill == 64) begin
            compress_block();
            pend_fill = 0;
        end
    endfunction

    // Update the predictor for one accepted beat; queue the digest on the end flag.
    function automatic void predict_beat(input logic [7:0] b, input logic pres,
                                         input logic fin, input logic typed,
                                         input logic [159:0] dig);
        logic [63:0]  total;
        t_digest_beat beat;
        int i;
        if (pres) begin
            msg_bit_count += 64'd8;
            absorb_byte(b);
        end
        if (fin) begin
            total = msg_bit_count;
            absorb_byte(PAD_MARK);
            while (pend_fill != int'(LEN_START)) absorb_byte(8'h00);
            for (i = 0; i < 8; i++) absorb_byte(total[63-8*i -: 8]);
            for (i = 0; i < NUM_WORDS; i++) begin
                beat.word = typed ? dig[159-32*i -: 32] : hash_words[i];
                beat.idx  = 3'(i);
                beat.last = (3'(i) == LAST_WORD);
                expected_digest_q.push_back(beat);
            end
            messages_closed++;
            clear_hash_state();
        end
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one beat, with an optional idle gap first, and hold it until taken.
    task automatic send_beat(input logic [7:0] b, input logic pres, input logic fin,
                             input logic typed, input logic [159:0] dig);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_message_byte   <= b;
        i_byte_present   <= pres;
        i_end_of_message <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_beat(b, pres, fin, typed, dig);
        beats_sent++;
        if (pres || fin) counted_items++;
    endtask

    // One random message; lengths favor short ones and block boundaries.
    task automatic send_message();
        int   len;
        int   pick;
        int   k;
        bit   end_with_byte;
        logic fin;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = $urandom_range(0, 8);
        end else if (pick < 85) begin
            len = BOUNDARY_LENS[$urandom_range(0, 7)];
        end else begin
            len = $urandom_range(9, 40);
        end
        end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
            end
            fin = end_with_byte && (k == len - 1);
            send_beat(8'($urandom_range(0, 255)), 1'b1, fin, 1'b0, NO_DIGEST);
        end
        if (!end_with_byte) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        end
    endtask

    // Stop offering and wait until every queued digest word has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_digest_q.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stall per cycle, plus one long hold-off.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) recv_beats_seen++;
            if (!long_hold_done && recv_beats_seen >= HOLD_AT_BEAT) begin
                long_hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Compare each accepted digest beat with the oldest expectation.
    always @(posedge i_clk) begin : check_digest
        t_digest_beat exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_digest_q.size() == 0) begin
                note_mismatch($sformatf("unexpected digest beat word=%08h index=%0d",
                                        o_digest_word, o_word_index));
            end else begin
                exp_beat = expected_digest_q.pop_front();
                words_checked++;
                if (o_digest_word !== exp_beat.word) begin
                    note_mismatch($sformatf("digest word %08h, expected %08h",
                                            o_digest_word, exp_beat.word));
                end
                if (o_word_index !== exp_beat.idx) begin
                    note_mismatch($sformatf("word index %0d, expected %0d",
                                            o_word_index, exp_beat.idx));
                end
                if (o_last_word !== exp_beat.last) begin
                    note_mismatch($sformatf("last flag %0b, expected %0b",
                                            o_last_word, exp_beat.last));
                end
            end
        end
    end

    // Main sequence: reset, directed beats, three phases of random messages with different idle mixes.
    initial begin
        int ph;
        int row;
        int phase_start;
        int phase_msgs;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_message_byte   <= 8'h00;
        i_byte_present   <= 1'b0;
        i_end_of_message <= 1'b0;
        clear_hash_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_DIRECTED; row++) begin
            send_beat(DIRECTED_ROWS[row].msg_byte, DIRECTED_ROWS[row].present,
                      DIRECTED_ROWS[row].finish, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].digest);
        end
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = counted_items;
            phase_msgs  = 0;
            while (counted_items - phase_start < RAND_ITEMS / 3 || phase_msgs < MIN_MSGS) begin
                send_message();
                phase_msgs++;
            end
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(posedge i_clk);
        $display("Covered %0d input beats (%0d carrying a byte or end) over %0d messages,",
                 beats_sent, counted_items, messages_closed);
        $display("with %0d digest words compared under three idling mixes.", words_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
